// ===== rtl/kpc_pkg.sv =====
// Package for the key press classifier: widths, register indexes, event codes
// and the struct types passed between the core and its submodules.
// No dependencies.
package kpc_pkg;

    localparam int TICK_W     = 32;
    localparam int MS_W       = 16;
    localparam int FREQ_W     = 10;
    localparam int KEY_W      = 8;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 16;

    // Repeat period is 1000 / frequency, so it never needs more than FREQ_W bits.
    localparam int                PERIOD_W      = FREQ_W;
    localparam logic [FREQ_W-1:0] PERIOD_NUMER  = FREQ_W'(1000);
    localparam int                DIV_STEPS     = FREQ_W;
    localparam int                DIV_CNT_W     = $clog2(DIV_STEPS + 1);

    localparam logic [MS_W-1:0]   DEBOUNCE_RST  = MS_W'(20);
    localparam logic [MS_W-1:0]   LONG_RST      = MS_W'(1000);

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_ACTIVE_LEVEL     = 3'd0,
        REG_DEBOUNCE_MS      = 3'd1,
        REG_LONG_PRESS_MS    = 3'd2,
        REG_REPEAT_FREQUENCY = 3'd3,
        REG_KEY_NUMBER       = 3'd4
    } cfg_index_t;

    typedef enum logic [1:0] {
        KIND_SHORT   = 2'd0,
        KIND_LONG    = 2'd1,
        KIND_RELEASE = 2'd2
    } event_kind_t;

    // Repeat timing as seen by the scan logic.
    typedef struct packed {
        logic                repeat_off;
        logic [PERIOD_W-1:0] period;
    } repeat_cfg_t;

    typedef struct packed {
        logic            active_level;
        logic [MS_W-1:0] debounce_ms;
        logic [MS_W-1:0] long_press_ms;
        repeat_cfg_t     rpt;
    } scan_cfg_t;

    typedef struct packed {
        logic              valid;
        event_kind_t       kind;
        logic [TICK_W-1:0] held_ms;
    } scan_event_t;

endpackage

// ===== rtl/kpc_period_div.sv =====
// Repeat period unit: restoring divider computing 1000 / repeat_frequency,
// one quotient bit per cycle, started by a write of the frequency register.
// Depends on kpc_pkg.
module kpc_period_div
    import kpc_pkg::*;
(
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              start,
    input  logic [FREQ_W-1:0] freq,
    output logic              busy,
    output repeat_cfg_t       rpt
);

    logic [DIV_CNT_W-1:0] cnt_reg, cnt_next;
    logic [FREQ_W-1:0]    divisor_reg, divisor_next;
    logic [FREQ_W-1:0]    dvd_reg, dvd_next;
    logic [FREQ_W-1:0]    rem_reg, rem_next;
    logic [PERIOD_W-1:0]  quo_reg, quo_next;
    logic                 off_reg, off_next;
    logic [FREQ_W:0]      trial;
    logic                 fits;

    assign trial = {rem_reg, dvd_reg[FREQ_W-1]};
    assign fits  = (trial >= {1'b0, divisor_reg});

    always_comb begin
        cnt_next     = cnt_reg;
        divisor_next = divisor_reg;
        dvd_next     = dvd_reg;
        rem_next     = rem_reg;
        quo_next     = quo_reg;
        off_next     = off_reg;
        if (start) begin
            divisor_next = freq;
            dvd_next     = PERIOD_NUMER;
            rem_next     = '0;
            quo_next     = '0;
            // zero frequency turns repeat off, no division needed
            off_next     = (freq == '0);
            cnt_next     = (freq == '0) ? '0 : DIV_CNT_W'(DIV_STEPS);
        end else if (cnt_reg != '0) begin
            cnt_next = cnt_reg - 1'b1;
            dvd_next = {dvd_reg[FREQ_W-2:0], 1'b0};
            quo_next = {quo_reg[PERIOD_W-2:0], fits};
            rem_next = fits ? FREQ_W'(trial - {1'b0, divisor_reg}) : trial[FREQ_W-1:0];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cnt_reg <= '0;
            off_reg <= 1'b1;
        end else begin
            cnt_reg <= cnt_next;
            off_reg <= off_next;
        end
        divisor_reg <= divisor_next;
        dvd_reg     <= dvd_next;
        rem_reg     <= rem_next;
        quo_reg     <= quo_next;
    end

    assign busy           = (cnt_reg != '0);
    assign rpt.repeat_off = off_reg;
    assign rpt.period     = quo_reg;

endmodule

// ===== rtl/kpc_scan.sv =====
// Per-scan classifier: key state registers and the compare/update logic that
// turns one scan into at most one event.
// Depends on kpc_pkg.
module kpc_scan
    import kpc_pkg::*;
(
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              step,
    input  logic              pin_level,
    input  logic [TICK_W-1:0] tick_ms,
    input  scan_cfg_t         cfg,
    output scan_event_t       evt
);

    logic              prev_level_reg, prev_level_next;
    logic [TICK_W-1:0] press_time_reg, press_time_next;
    logic              in_long_reg, in_long_next;
    logic [TICK_W-1:0] repeat_time_reg, repeat_time_next;

    logic              now_pressed, was_pressed;
    logic [TICK_W-1:0] held;
    logic [TICK_W-1:0] since_repeat;

    assign now_pressed  = (pin_level == cfg.active_level);
    assign was_pressed  = (prev_level_reg == cfg.active_level);
    assign held         = tick_ms - press_time_reg;
    assign since_repeat = tick_ms - repeat_time_reg;

    always_comb begin
        prev_level_next  = pin_level;
        press_time_next  = press_time_reg;
        in_long_next     = in_long_reg;
        repeat_time_next = repeat_time_reg;
        evt.valid        = 1'b0;
        evt.kind         = KIND_SHORT;
        evt.held_ms      = held;
        if (now_pressed && !was_pressed) begin
            press_time_next = tick_ms;
        end else if (!now_pressed && was_pressed) begin
            // release too short: no event, long press flag stays until idle
            if (held >= TICK_W'(cfg.debounce_ms)) begin
                evt.valid        = 1'b1;
                evt.kind         = in_long_reg ? KIND_RELEASE : KIND_SHORT;
                in_long_next     = 1'b0;
                repeat_time_next = tick_ms;
            end
            press_time_next = tick_ms;
        end else if (now_pressed) begin
            if (held >= TICK_W'(cfg.long_press_ms)) begin
                if (!in_long_reg) begin
                    in_long_next     = 1'b1;
                    repeat_time_next = tick_ms;
                    evt.valid        = 1'b1;
                    evt.kind         = KIND_LONG;
                end else if (!cfg.rpt.repeat_off &&
                             since_repeat >= TICK_W'(cfg.rpt.period)) begin
                    repeat_time_next = tick_ms;
                    evt.valid        = 1'b1;
                    evt.kind         = KIND_LONG;
                end
            end
        end else begin
            in_long_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            prev_level_reg  <= 1'b1;
            press_time_reg  <= '0;
            in_long_reg     <= 1'b0;
            repeat_time_reg <= '0;
        end else if (step) begin
            prev_level_reg  <= prev_level_next;
            press_time_reg  <= press_time_next;
            in_long_reg     <= in_long_next;
            repeat_time_reg <= repeat_time_next;
        end
    end

endmodule

// ===== rtl/key_press_classifier_core.sv =====
// Key press classifier top level: config registers, input and result stages.
// Depends on kpc_pkg, kpc_period_div, kpc_scan.
//
// Usage:
//   s_ channel: one scan per transaction (pin level + millisecond timestamp).
//   m_ channel: at most one event per scan (kind, key number, hold time).
//   Config: cfg_wr_en / cfg_index / cfg_data, no read-back.
// Path: a scan accepted on the s_ channel goes through the input register, then
//   the result register, before its event shows on m_valid.
// Throughput: one scan per cycle while m_ready stays high and the divider is idle;
//   scans that produce no event leave the result channel untouched.
// Writing repeat_frequency with a nonzero value starts the period divider:
//   s_ready stays low while it runs, one quotient bit per cycle.
// Reset (aresetn low, synchronous) restores the register defaults, clears the
//   key state and empties both stages.
// Receiver stall: the result register holds its event; the input register
//   keeps one scan, then s_ready drops until m_ready returns.
module key_press_classifier_core
    import kpc_pkg::*;
(
    input  logic                  aclk,
    input  logic                  aresetn,

    input  logic                  cfg_wr_en,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data,

    input  logic                  s_valid,
    output logic                  s_ready,
    input  logic                  s_pin_level,
    input  logic [TICK_W-1:0]     s_tick_ms,

    output logic                  m_valid,
    input  logic                  m_ready,
    output logic [1:0]            m_event_kind,
    output logic [KEY_W-1:0]      m_event_key,
    output logic [TICK_W-1:0]     m_held_ms
);

    logic              active_level_reg;
    logic [MS_W-1:0]   debounce_reg;
    logic [MS_W-1:0]   long_press_reg;
    logic [KEY_W-1:0]  key_number_reg;

    logic              div_start;
    logic              div_busy;
    repeat_cfg_t       rpt;
    scan_cfg_t         scan_cfg;
    scan_event_t       evt;

    logic              in_valid_reg;
    logic              in_pin_reg;
    logic [TICK_W-1:0] in_tick_reg;

    logic              out_valid_reg, out_valid_next;
    event_kind_t       out_kind_reg;
    logic [KEY_W-1:0]  out_key_reg;
    logic [TICK_W-1:0] out_held_reg;

    logic              out_free;
    logic              step;
    logic              in_advance;
    logic              s_take;

    // register writes; unknown indexes fall through
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            active_level_reg <= 1'b0;
            debounce_reg     <= DEBOUNCE_RST;
            long_press_reg   <= LONG_RST;
            key_number_reg   <= '0;
        end else if (cfg_wr_en) begin
            unique case (cfg_index)
                REG_ACTIVE_LEVEL:  active_level_reg <= cfg_data[0];
                REG_DEBOUNCE_MS:   debounce_reg     <= cfg_data;
                REG_LONG_PRESS_MS: long_press_reg   <= cfg_data;
                REG_KEY_NUMBER:    key_number_reg   <= cfg_data[KEY_W-1:0];
                default: ;
            endcase
        end
    end

    assign div_start = cfg_wr_en && (cfg_index == REG_REPEAT_FREQUENCY);

    kpc_period_div u_div (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (div_start),
        .freq    (cfg_data[FREQ_W-1:0]),
        .busy    (div_busy),
        .rpt     (rpt)
    );

    assign scan_cfg.active_level  = active_level_reg;
    assign scan_cfg.debounce_ms   = debounce_reg;
    assign scan_cfg.long_press_ms = long_press_reg;
    assign scan_cfg.rpt           = rpt;

    assign out_free   = !out_valid_reg || m_ready;
    assign step       = in_valid_reg && out_free;
    assign in_advance = !in_valid_reg || out_free;
    assign s_ready    = in_advance && !div_busy;
    assign s_take     = s_valid && s_ready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (in_advance) begin
            in_valid_reg <= s_take;
        end
        if (s_take) begin
            in_pin_reg  <= s_pin_level;
            in_tick_reg <= s_tick_ms;
        end
    end

    kpc_scan u_scan (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .step      (step),
        .pin_level (in_pin_reg),
        .tick_ms   (in_tick_reg),
        .cfg       (scan_cfg),
        .evt       (evt)
    );

    always_comb begin
        out_valid_next = out_valid_reg;
        if (out_free) begin
            out_valid_next = step && evt.valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else begin
            out_valid_reg <= out_valid_next;
        end
        if (step && evt.valid) begin
            out_kind_reg <= evt.kind;
            out_key_reg  <= key_number_reg;
            out_held_reg <= evt.held_ms;
        end
    end

    assign m_valid      = out_valid_reg;
    assign m_event_kind = out_kind_reg;
    assign m_event_key  = out_key_reg;
    assign m_held_ms    = out_held_reg;

endmodule

// ===== rtl/kpc_checker.sv =====
// Port-level checks for key_press_classifier_core, bound to the top level.
// Depends on kpc_pkg.
module kpc_checker
    import kpc_pkg::*;
(
    input logic                  aclk,
    input logic                  aresetn,
    input logic                  cfg_wr_en,
    input logic [CFG_IDX_W-1:0]  cfg_index,
    input logic [CFG_DATA_W-1:0] cfg_data,
    input logic                  s_ready,
    input logic                  m_valid,
    input logic                  m_ready,
    input logic [1:0]            m_event_kind,
    input logic [TICK_W-1:0]     m_held_ms
);

    // stalled result transaction holds
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_event_kind) && $stable(m_held_ms))
        else $error("result changed while stalled");

    a_kind_legal: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> (m_event_kind == KIND_SHORT || m_event_kind == KIND_LONG ||
                     m_event_kind == KIND_RELEASE))
        else $error("illegal event kind");

    // nonzero frequency write starts the divider, which blocks scans
    a_div_stall: assert property (@(posedge aclk)
        aresetn && cfg_wr_en && cfg_index == REG_REPEAT_FREQUENCY &&
        cfg_data[FREQ_W-1:0] != '0 |=> !s_ready)
        else $error("scan accepted during period division");

    a_reset_empty: assert property (@(posedge aclk)
        !aresetn |=> !m_valid)
        else $error("result valid after reset");

endmodule

bind key_press_classifier_core kpc_checker u_kpc_checker (
    .aclk         (aclk),
    .aresetn      (aresetn),
    .cfg_wr_en    (cfg_wr_en),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .s_ready      (s_ready),
    .m_valid      (m_valid),
    .m_ready      (m_ready),
    .m_event_kind (m_event_kind),
    .m_held_ms    (m_held_ms)
);
